// ----- src/guide_line_point_warp_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Guide line point warp - assertion macros
// Shared property macros for the checker file of the warp unit.
// ----------------------------------------------------------------------------
`ifndef GUIDE_LINE_POINT_WARP_UNIT_DEFINES_SVH
`define GUIDE_LINE_POINT_WARP_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define GLW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is asserted.
`define GLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define GLW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- src/glw_pkg.sv -----
// ----------------------------------------------------------------------------
// Guide line point warp - package
// Item codes, register indexes and the item structures used across modules.
// ----------------------------------------------------------------------------
`default_nettype none

package glw_pkg;

    localparam int COORD_W = 16;
    localparam int EXT_W   = 15;
    localparam int CNT_W   = 11;
    localparam int GI_W    = 10;
    localparam int ADDR_W  = 17;   // wide enough to compare against any store depth below 131072

    typedef enum logic [1:0] {
        OP_LOAD_TOP = 2'd0,
        OP_LOAD_BOT = 2'd1,
        OP_WARP     = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_TOP_CNT = 2'd2,
        CFG_BOT_CNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic [GI_W-1:0]           gi;
        logic [1:0]                op;
    } t_item;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
    } t_sign;

    localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

`default_nettype wire

// ----- src/glw_div.sv -----
// ----------------------------------------------------------------------------
// Guide line point warp - pipelined divider
// Restoring division, one quotient bit per stage, several lanes sharing one
// divisor. Flags quotients that do not fit in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module glw_div #(
    parameter int N_W   = 25,
    parameter int D_W   = 15,
    parameter int Q_W   = 10,
    parameter int LANES = 2,
    parameter int TAG_W = 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic [TAG_W-1:0]               i_tag,
    input  wire logic [LANES-1:0][N_W-1:0]      i_num,
    input  wire logic [D_W-1:0]                 i_den,
    output logic                                o_valid,
    output logic [TAG_W-1:0]                    o_tag,
    output logic [LANES-1:0][Q_W-1:0]           o_quo,
    output logic [LANES-1:0]                    o_ovf
);

    localparam int W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

    logic [Q_W-1:0]              r_v;
    logic [TAG_W-1:0]            r_tag [Q_W];
    logic [LANES-1:0][W-1:0]     r_rem [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_q   [Q_W];
    logic [LANES-1:0]            r_ovf [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_st
        logic                       sv;
        logic [TAG_W-1:0]           st;
        logic [LANES-1:0][W-1:0]    srem;
        logic [LANES-1:0][W-1:0]    n_rem;
        logic [LANES-1:0][Q_W-1:0]  sq;
        logic [LANES-1:0][Q_W-1:0]  n_q;
        logic [LANES-1:0]           sovf;
        logic [W-1:0]               dsh;

        if (s == 0) begin : g_first
            always_comb begin
                sv = i_valid;
                st = i_tag;
                sq = '0;
                for (int l = 0; l < LANES; l++) begin
                    srem[l] = W'(i_num[l]);
                    sovf[l] = W'(i_num[l]) >= (W'(i_den) << Q_W);
                end
            end
        end else begin : g_next
            assign sv   = r_v[s-1];
            assign st   = r_tag[s-1];
            assign sq   = r_q[s-1];
            assign srem = r_rem[s-1];
            assign sovf = r_ovf[s-1];
        end

        assign dsh = W'(i_den) << (Q_W - 1 - s);

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (srem[l] >= dsh) begin
                    n_rem[l] = srem[l] - dsh;
                    n_q[l]   = sq[l] | (Q_W'(1) << (Q_W - 1 - s));
                end else begin
                    n_rem[l] = srem[l];
                    n_q[l]   = sq[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= sv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s] <= st;
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
                r_ovf[s] <= sovf;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_tag   = r_tag[Q_W-1];
    assign o_quo   = r_q[Q_W-1];
    assign o_ovf   = r_ovf[Q_W-1];

endmodule

`default_nettype wire

// ----- src/glw_idx.sv -----
// ----------------------------------------------------------------------------
// Guide line point warp - guide index picker
// Scales point x by (count - 1), divides by the extent width and clamps the
// quotient to the last guide entry, for the top and bottom guides at once.
// ----------------------------------------------------------------------------
`default_nettype none

module glw_idx #(
    parameter int GUIDE_DEPTH = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire glw_pkg::t_item                    i_item,
    input  wire logic [glw_pkg::EXT_W-1:0]         i_width,
    input  wire logic [$clog2(GUIDE_DEPTH)-1:0]    i_cm1_top,
    input  wire logic [$clog2(GUIDE_DEPTH)-1:0]    i_cm1_bot,
    output logic                                   o_valid,
    output glw_pkg::t_item                         o_item,
    output logic [$clog2(GUIDE_DEPTH)-1:0]         o_top_idx,
    output logic [$clog2(GUIDE_DEPTH)-1:0]         o_bot_idx
);

    localparam int IDX_W = $clog2(GUIDE_DEPTH);
    localparam int P_W   = glw_pkg::EXT_W + IDX_W;

    logic                      r_v0;
    glw_pkg::t_item            r_item0;
    logic [1:0][P_W-1:0]       r_prod;
    logic [1:0][P_W-1:0]       n_prod;
    logic                      x_pos;
    logic [P_W-1:0]            x_ext;

    logic [1:0][IDX_W-1:0]     quo;
    logic [1:0]                ovf;

    // Only a positive x moves away from the first entry.
    assign x_pos = !i_item.x[glw_pkg::COORD_W-1] && (|i_item.x[glw_pkg::COORD_W-2:0]);
    assign x_ext = P_W'(i_item.x[glw_pkg::COORD_W-2:0]);

    always_comb begin
        n_prod[0] = x_pos ? x_ext * P_W'(i_cm1_top) : '0;
        n_prod[1] = x_pos ? x_ext * P_W'(i_cm1_bot) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item0 <= i_item;
            r_prod  <= n_prod;
        end
    end

    glw_div #(
        .N_W   (P_W),
        .D_W   (glw_pkg::EXT_W),
        .Q_W   (IDX_W),
        .LANES (2),
        .TAG_W ($bits(glw_pkg::t_item))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v0),
        .i_tag   (r_item0),
        .i_num   (r_prod),
        .i_den   (i_width),
        .o_valid (o_valid),
        .o_tag   (o_item),
        .o_quo   (quo),
        .o_ovf   (ovf)
    );

    // Clamp to the last entry of each guide.
    assign o_top_idx = (ovf[0] || quo[0] > i_cm1_top) ? i_cm1_top : quo[0];
    assign o_bot_idx = (ovf[1] || quo[1] > i_cm1_bot) ? i_cm1_bot : quo[1];

endmodule

`default_nettype wire

// ----- src/guide_line_point_warp_unit.sv -----
// ----------------------------------------------------------------------------
// Guide line point warp - top level
// Warps points between a top and a bottom guide polyline.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
//   high (extent width, extent height, top count, bottom count). Write only
//   while no transaction is in flight.
//   Input stream: s_tuser carries the item kind (load top point, load bottom
//   point, warp point). Loads fill the guide stores and give no output; a
//   warp gives one output transaction with the blended point.
//   Throughput: one transaction per cycle while s_tready is high. From an input
//   transaction to its output the pipeline has one product stage, one index
//   divider stage per index bit, a store read, four blend stages, sixteen
//   stages of the blend divider and the output stage.
//   Reset clears all valid bits and sets the registers to their defaults; the
//   guide stores are not cleared and must be loaded before use.
//   When m_tready stays low, one more result parks in a skid register, then
//   s_tready drops and the whole pipeline holds until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module guide_line_point_warp_unit #(
    parameter int GUIDE_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [14:0] i_cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // guide_index[9:0], coord_x[25:10], coord_y[41:26]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // warped_x[15:0], warped_y[31:16]
);

    localparam int IDX_W = $clog2(GUIDE_DEPTH);
    localparam int CW    = glw_pkg::COORD_W;
    localparam int AW    = glw_pkg::ADDR_W;

    // ---------------- configuration registers ----------------
    logic [glw_pkg::EXT_W-1:0] r_width, r_height;
    logic [glw_pkg::CNT_W-1:0] r_top_cnt, r_bot_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= glw_pkg::EXT_W'(1);
            r_height  <= glw_pkg::EXT_W'(1);
            r_top_cnt <= glw_pkg::CNT_W'(2);
            r_bot_cnt <= glw_pkg::CNT_W'(2);
        end else if (i_cfg_we) begin
            unique case (glw_pkg::t_cfg_idx'(i_cfg_idx))
                glw_pkg::CFG_WIDTH:   r_width   <= i_cfg_data;
                glw_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data;
                glw_pkg::CFG_TOP_CNT: r_top_cnt <= i_cfg_data[glw_pkg::CNT_W-1:0];
                glw_pkg::CFG_BOT_CNT: r_bot_cnt <= i_cfg_data[glw_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [glw_pkg::EXT_W-1:0] width_eff, height_eff;
    logic [AW-1:0]             top_c, bot_c, top_eff, bot_eff, top_m1, bot_m1;
    logic [IDX_W-1:0]          cm1_top, cm1_bot;

    assign width_eff  = (r_width == '0)  ? glw_pkg::EXT_W'(1) : r_width;
    assign height_eff = (r_height == '0) ? glw_pkg::EXT_W'(1) : r_height;
    assign top_c      = AW'(r_top_cnt);
    assign bot_c      = AW'(r_bot_cnt);

    // Clamp each count to 1 .. GUIDE_DEPTH.
    always_comb begin
        priority if (top_c == '0)               top_eff = AW'(1);
        else if (top_c > AW'(GUIDE_DEPTH))      top_eff = AW'(GUIDE_DEPTH);
        else                                    top_eff = top_c;
        priority if (bot_c == '0)               bot_eff = AW'(1);
        else if (bot_c > AW'(GUIDE_DEPTH))      bot_eff = AW'(GUIDE_DEPTH);
        else                                    bot_eff = bot_c;
    end

    assign top_m1  = top_eff - AW'(1);
    assign bot_m1  = bot_eff - AW'(1);
    assign cm1_top = top_m1[IDX_W-1:0];
    assign cm1_bot = bot_m1[IDX_W-1:0];

    // ---------------- pipeline control ----------------
    logic r_ov, r_sv;
    logic adv;

    assign adv      = !r_sv;
    assign s_tready = adv;

    glw_pkg::t_item in_item;
    assign in_item.op = s_tuser;
    assign in_item.gi = s_tdata[9:0];
    assign in_item.x  = s_tdata[25:10];
    assign in_item.y  = s_tdata[41:26];

    // ---------------- index picking ----------------
    logic             ix_v;
    glw_pkg::t_item   ix_item;
    logic [IDX_W-1:0] ix_top, ix_bot;

    glw_idx #(
        .GUIDE_DEPTH (GUIDE_DEPTH)
    ) u_idx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (adv),
        .i_valid   (s_tvalid),
        .i_item    (in_item),
        .i_width   (width_eff),
        .i_cm1_top (cm1_top),
        .i_cm1_bot (cm1_bot),
        .o_valid   (ix_v),
        .o_item    (ix_item),
        .o_top_idx (ix_top),
        .o_bot_idx (ix_bot)
    );

    // ---------------- guide stores ----------------
    logic [2*CW-1:0] top_mem [GUIDE_DEPTH];
    logic [2*CW-1:0] bot_mem [GUIDE_DEPTH];
    logic [AW-1:0]   gi_ext;
    logic [IDX_W-1:0] wr_addr;
    logic            gi_ok, wr_top, wr_bot;
    logic [2*CW-1:0] wr_data;

    assign gi_ext  = AW'(ix_item.gi);
    assign gi_ok   = gi_ext < AW'(GUIDE_DEPTH);
    assign wr_addr = gi_ext[IDX_W-1:0];
    assign wr_data = {ix_item.y, ix_item.x};
    assign wr_top  = ix_v && gi_ok && (ix_item.op == glw_pkg::OP_LOAD_TOP);
    assign wr_bot  = ix_v && gi_ok && (ix_item.op == glw_pkg::OP_LOAD_BOT);

    logic [2*CW-1:0]        r_tp, r_bp;
    logic                   r_mv;
    logic signed [CW-1:0]   r_my;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (wr_top) begin
                top_mem[wr_addr] <= wr_data;
            end
            r_tp <= top_mem[ix_top];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (wr_bot) begin
                bot_mem[wr_addr] <= wr_data;
            end
            r_bp <= bot_mem[ix_bot];
        end
    end

    // ---------------- blend: top*h + (bot - top)*y ----------------
    logic                    r_b1v, r_b2v, r_b3v, r_b4v;
    logic signed [2*CW-1:0]  r_p1x, r_p1y, r_p1x2, r_p1y2;
    logic signed [CW:0]      r_dx, r_dy;
    logic signed [CW-1:0]    r_b1y;
    logic signed [2*CW:0]    r_p2x, r_p2y;
    logic signed [2*CW+1:0]  r_sx, r_sy;
    logic [1:0][2*CW+1:0]    r_mag;
    glw_pkg::t_sign          r_sgn;

    logic signed [CW-1:0]    tx, ty, bx, by;
    logic signed [CW:0]      h_s;

    assign tx  = r_tp[CW-1:0];
    assign ty  = r_tp[2*CW-1:CW];
    assign bx  = r_bp[CW-1:0];
    assign by  = r_bp[2*CW-1:CW];
    assign h_s = $signed({2'b00, height_eff});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv  <= 1'b0;
            r_b1v <= 1'b0;
            r_b2v <= 1'b0;
            r_b3v <= 1'b0;
            r_b4v <= 1'b0;
        end else if (adv) begin
            // drop loads and unused codes here: only warps give a result
            r_mv  <= ix_v && (ix_item.op == glw_pkg::OP_WARP);
            r_b1v <= r_mv;
            r_b2v <= r_b1v;
            r_b3v <= r_b2v;
            r_b4v <= r_b3v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_my   <= ix_item.y;
            // stage 1
            r_p1x  <= (2*CW)'(tx * h_s);
            r_p1y  <= (2*CW)'(ty * h_s);
            r_dx   <= $signed({bx[CW-1], bx}) - $signed({tx[CW-1], tx});
            r_dy   <= $signed({by[CW-1], by}) - $signed({ty[CW-1], ty});
            r_b1y  <= r_my;
            // stage 2
            r_p2x  <= r_dx * r_b1y;
            r_p2y  <= r_dy * r_b1y;
            r_p1x2 <= r_p1x;
            r_p1y2 <= r_p1y;
            // stage 3
            r_sx   <= (2*CW+2)'(r_p1x2) + (2*CW+2)'(r_p2x);
            r_sy   <= (2*CW+2)'(r_p1y2) + (2*CW+2)'(r_p2y);
            // stage 4: sign and magnitude
            r_sgn.neg_x <= r_sx[2*CW+1];
            r_sgn.neg_y <= r_sy[2*CW+1];
            r_mag[0]    <= r_sx[2*CW+1] ? -r_sx : r_sx;
            r_mag[1]    <= r_sy[2*CW+1] ? -r_sy : r_sy;
        end
    end

    // ---------------- divide by extent height ----------------
    logic                 dv_v;
    glw_pkg::t_sign       dv_sgn;
    logic [1:0][CW-1:0]   dv_q;
    logic [1:0]           dv_ovf;

    glw_div #(
        .N_W   (2*CW+2),
        .D_W   (glw_pkg::EXT_W),
        .Q_W   (CW),
        .LANES (2),
        .TAG_W ($bits(glw_pkg::t_sign))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_b4v),
        .i_tag   (r_sgn),
        .i_num   (r_mag),
        .i_den   (height_eff),
        .o_valid (dv_v),
        .o_tag   (dv_sgn),
        .o_quo   (dv_q),
        .o_ovf   (dv_ovf)
    );

    // Truncate toward zero, then saturate.
    logic [1:0]          neg;
    logic [1:0][CW-1:0]  res;

    assign neg = {dv_sgn.neg_y, dv_sgn.neg_x};

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (neg[l]) begin
                if (dv_ovf[l] || dv_q[l] > CW'(glw_pkg::SAT_MIN)) res[l] = glw_pkg::SAT_MIN;
                else                                                res[l] = -dv_q[l];
            end else begin
                if (dv_ovf[l] || dv_q[l] > CW'(glw_pkg::SAT_MAX)) res[l] = glw_pkg::SAT_MAX;
                else                                                res[l] = dv_q[l];
            end
        end
    end

    // ---------------- output register and skid ----------------
    logic [2*CW-1:0] r_od, r_sd;
    logic            pv;

    assign pv = dv_v && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || m_tready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= pv;
            end
        end else if (pv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || m_tready) begin
            r_od <= r_sv ? r_sd : {res[1], res[0]};
        end else if (pv) begin
            r_sd <= {res[1], res[0]};
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_od;

endmodule

`default_nettype wire

// ----- src/glw_checker.sv -----
// ----------------------------------------------------------------------------
// Guide line point warp - port checker
// Watches the stream ports of the warp unit over time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "guide_line_point_warp_unit_defines.svh"

module glw_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // a stalled output transaction holds
    `GLW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // backpressure only while a result is waiting
    `GLW_ASSERT_IMPLY(a_ready_low, i_clk, i_rst_n, !s_tready, m_tvalid)

    // input side closes only after a stalled output cycle
    `GLW_ASSERT_IMPLY(a_ready_fall, i_clk, i_rst_n, $fell(s_tready), $past(m_tvalid && !m_tready))

    // reset empties the output and opens the input
    `GLW_ASSERT_NEXT_ALWAYS(a_reset, i_clk, !i_rst_n, !m_tvalid && s_tready)

endmodule

bind guide_line_point_warp_unit glw_checker u_glw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- dv/guide_line_point_warp_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Guide line point warp - unit testbench
// Loads top and bottom guide points, warps points between them and checks
// every output transaction against a cycle-free predictor of the blend or a directed row's expected point.
// ----------------------------------------------------------------------------
`default_nettype none

module guide_line_point_warp_unit_test;

    localparam int DEPTH      = 1024;
    localparam int SETTLE     = 40;     // pipeline depth plus margin
    localparam int STALL_MAX  = 5000;
    localparam int PHASE_ITEMS = 300;

    typedef struct {
        glw_pkg::t_op               op;
        logic [1:0]                 raw_op;
        logic [glw_pkg::GI_W-1:0]   gi;
        logic signed [15:0]         x;
        logic signed [15:0]         y;
        bit                         typed;
        logic signed [15:0]         ex;
        logic signed [15:0]         ey;
    } t_row;

    typedef struct {
        logic signed [15:0] wx;
        logic signed [15:0] wy;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [14:0] i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // guide_index[9:0], coord_x[25:10], coord_y[41:26]
    logic [1:0]  s_tuser = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // warped_x[15:0], warped_y[31:16]

    guide_line_point_warp_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] top_x [DEPTH];
    logic signed [15:0] top_y [DEPTH];
    logic signed [15:0] bot_x [DEPTH];
    logic signed [15:0] bot_y [DEPTH];
    bit                 top_ok [DEPTH];
    bit                 bot_ok [DEPTH];
    logic [14:0]        ext_w = 15'd1;
    logic [14:0]        ext_h = 15'd1;
    logic [10:0]        top_cnt = 11'd2;
    logic [10:0]        bot_cnt = 11'd2;

    t_point pending_points[$];
    int     mismatches = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    int     stall_cycles = 0;

    function automatic int eff_cnt(logic [10:0] c);
        if (c == 0) return 1;
        if (c > DEPTH) return DEPTH;
        return c;
    endfunction

    function automatic int guide_slot(logic signed [15:0] x, int cnt);
        longint q;
        longint w;
        w = (ext_w == 0) ? 1 : ext_w;
        if (x <= 0) return 0;
        q = (longint'(x) * (cnt - 1)) / w;
        if (q > cnt - 1) q = cnt - 1;
        return int'(q);
    endfunction

    function automatic logic signed [15:0] blend_coord(logic signed [15:0] b,
                                                      logic signed [15:0] t,
                                                      logic signed [15:0] y);
        longint h;
        longint num;
        longint r;
        h = (ext_h == 0) ? 1 : ext_h;
        num = longint'(b) * longint'(y) + longint'(t) * (h - longint'(y));
        r = num / h;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Apply one accepted item to the guide stores or the expected points.
    task automatic absorb_item(t_row r);
        int     ti;
        int     bi;
        t_point p;
        case (r.raw_op)
            glw_pkg::OP_LOAD_TOP: begin
                top_x[r.gi] = r.x; top_y[r.gi] = r.y; top_ok[r.gi] = 1'b1;
            end
            glw_pkg::OP_LOAD_BOT: begin
                bot_x[r.gi] = r.x; bot_y[r.gi] = r.y; bot_ok[r.gi] = 1'b1;
            end
            glw_pkg::OP_WARP: begin
                if (r.typed) begin
                    p.wx = r.ex; p.wy = r.ey;
                end else begin
                    ti = guide_slot(r.x, eff_cnt(top_cnt));
                    bi = guide_slot(r.x, eff_cnt(bot_cnt));
                    p.wx = blend_coord(bot_x[bi], top_x[ti], r.y);
                    p.wy = blend_coord(bot_y[bi], top_y[ti], r.y);
                end
                pending_points.push_back(p);
            end
            default: ;
        endcase
    endtask

    task automatic send_item(t_row r);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < send_idle) begin
                s_tvalid <= 1'b0;
            end else begin
                break;
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.raw_op;
        s_tdata  <= {6'b0, r.y, r.x, r.gi};
        do @(posedge i_clk); while (!s_tready);
        absorb_item(r);
    endtask

    task automatic write_reg(glw_pkg::t_cfg_idx idx, logic [14:0] val);
        @(negedge i_clk);
        s_tvalid   <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            glw_pkg::CFG_WIDTH:   ext_w = val;
            glw_pkg::CFG_HEIGHT:  ext_h = val;
            glw_pkg::CFG_TOP_CNT: top_cnt = val[10:0];
            glw_pkg::CFG_BOT_CNT: bot_cnt = val[10:0];
        endcase
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(string what, logic signed [15:0] got,
                                 logic signed [15:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic signed [15:0] guide_coord();
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'($urandom_range(2000)) - 16'sd1000;
    endfunction

    function automatic t_row random_row();
        t_row r;
        int   sel;
        int   we;
        int   he;
        int   ti;
        int   bi;
        we = (ext_w == 0) ? 1 : ext_w;
        he = (ext_h == 0) ? 1 : ext_h;
        r = '{op: glw_pkg::OP_WARP, default: '0};
        sel = $urandom_range(99);
        if (sel < 20) begin
            r.raw_op = glw_pkg::OP_LOAD_TOP;
            r.gi = ($urandom_range(7) == 0) ? 10'($urandom)
                                            : 10'($urandom_range(eff_cnt(top_cnt) - 1));
            r.x = guide_coord(); r.y = guide_coord();
        end else if (sel < 40) begin
            r.raw_op = glw_pkg::OP_LOAD_BOT;
            r.gi = ($urandom_range(7) == 0) ? 10'($urandom)
                                            : 10'($urandom_range(eff_cnt(bot_cnt) - 1));
            r.x = guide_coord(); r.y = guide_coord();
        end else if (sel < 95) begin
            r.raw_op = glw_pkg::OP_WARP;
            r.gi = 10'($urandom);
            case ($urandom_range(9))
                0, 1:    r.x = 16'($urandom);
                2:       r.x = -16'($urandom_range(50));
                3:       r.x = 16'(we + $urandom_range(50));
                default: r.x = 16'($urandom_range(we));
            endcase
            r.y = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(he));
            ti = guide_slot(r.x, eff_cnt(top_cnt));
            bi = guide_slot(r.x, eff_cnt(bot_cnt));
            // steer away from entries never loaded; entry 0 is always loaded
            if (!top_ok[ti] || !bot_ok[bi]) r.x = '0;
        end else begin
            r.raw_op = 2'd3;
            r.gi = 10'($urandom); r.x = 16'($urandom); r.y = 16'($urandom);
        end
        return r;
    endfunction

    // output check
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                flag_mismatch("unexpected output transaction", m_tdata[15:0], 16'sd0);
            end else begin
                want = pending_points.pop_front();
                if (m_tdata[15:0] !== want.wx) flag_mismatch("warped_x", m_tdata[15:0], want.wx);
                if (m_tdata[31:16] !== want.wy) flag_mismatch("warped_y", m_tdata[31:16], want.wy);
            end
        end
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    t_row directed [] = '{
        '{glw_pkg::OP_LOAD_TOP, glw_pkg::OP_LOAD_TOP, 10'd0,
          16'sd100, 16'sd200, 0, 0, 0},
        '{glw_pkg::OP_LOAD_TOP, glw_pkg::OP_LOAD_TOP, 10'd1,
          -16'sd32768, 16'sd32767, 0, 0, 0},
        '{glw_pkg::OP_LOAD_BOT, glw_pkg::OP_LOAD_BOT, 10'd0,
          16'sd300, -16'sd400, 0, 0, 0},
        '{glw_pkg::OP_LOAD_BOT, glw_pkg::OP_LOAD_BOT, 10'd1,
          16'sd32767, -16'sd32768, 0, 0, 0},
        '{glw_pkg::OP_LOAD_TOP, glw_pkg::OP_LOAD_TOP, 10'd1023,
          16'sd5, 16'sd6, 0, 0, 0},
        '{glw_pkg::OP_LOAD_BOT, glw_pkg::OP_LOAD_BOT, 10'd1023,
          -16'sd7, -16'sd8, 0, 0, 0},
        '{glw_pkg::OP_WARP, 2'd3, 10'd1023,
          -16'sd1, -16'sd1, 0, 0, 0},
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd0,
          16'sd0, 16'sd0, 1, 16'sd100, 16'sd200},
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd1023,
          16'sd1, 16'sd1, 1, 16'sd32767, -16'sd32768},
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd0,
          -16'sd32768, 16'sd0, 1, 16'sd100, 16'sd200},
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd0,
          16'sd32767, 16'sd1, 1, 16'sd32767, -16'sd32768},
        // extrapolation far outside the extent saturates
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd0,
          16'sd1, 16'sd32767, 0, 0, 0},
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd0,
          16'sd1, -16'sd32768, 0, 0, 0},
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd0,
          16'sd0, 16'sd32767, 0, 0, 0},
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd0,
          16'sd0, -16'sd32768, 0, 0, 0},
        '{glw_pkg::OP_WARP, glw_pkg::OP_WARP, 10'd0,
          16'sd0, 16'sd1, 0, 0, 0}
    };

    // width, height, top count, bottom count per phase
    logic [14:0] phase_cfg [6][4] = '{
        '{15'd0,     15'd0,     15'd0,     15'd2047},
        '{15'd32767, 15'd32767, 15'd1024,  15'd1024},
        '{15'd100,   15'd50,    15'd16,    15'd9},
        '{15'd7,     15'd32767, 15'd1,     15'd3},
        '{15'd32767, 15'd1,     15'd5,     15'd1024},
        '{15'h5555,  15'h2AAA,  15'h7FFF,  15'h0400}
    };

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k]) send_item(directed[k]);
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_settle();
            write_reg(glw_pkg::CFG_WIDTH,   phase_cfg[ph][0]);
            write_reg(glw_pkg::CFG_HEIGHT,  phase_cfg[ph][1]);
            write_reg(glw_pkg::CFG_TOP_CNT, phase_cfg[ph][2]);
            write_reg(glw_pkg::CFG_BOT_CNT, phase_cfg[ph][3]);
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            case (ph / 2)
                0: begin send_idle = 8;  recv_idle = 59; end
                1: begin send_idle = 59; recv_idle = 8;  end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_row());
        end
        drain_and_settle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/glw_pkg.sv
src/glw_div.sv
src/glw_idx.sv
src/guide_line_point_warp_unit.sv
src/glw_checker.sv
dv/guide_line_point_warp_unit_test.sv
